>>> rtl/gor_pkg.sv
// Package with the direction codes, register indexes and rotation map of the orientation detector.
`timescale 1ns / 1ps
`default_nettype none

package gor_pkg;

    typedef enum logic [2:0] {
        DIR_UNKNOWN = 3'd0,
        DIR_POS_X   = 3'd1,
        DIR_NEG_X   = 3'd2,
        DIR_POS_Y   = 3'd3,
        DIR_NEG_Y   = 3'd4
    } t_dir;

    typedef enum logic [2:0] {
        REG_SENSOR_READY    = 3'd0,
        REG_AXIS_MIN        = 3'd1,
        REG_HYSTERESIS      = 3'd2,
        REG_STABLE_TIME     = 3'd3,
        REG_SAMPLE_INTERVAL = 3'd4,
        REG_MOUNT_TURNS     = 3'd5,
        REG_AUTO_ROTATE     = 3'd6
    } t_reg_idx;

    localparam int unsigned ADDR_W = 5;

    localparam logic [13:0] AXIS_MIN_RESET        = 14'd500;
    localparam logic [13:0] HYSTERESIS_RESET      = 14'd150;
    localparam logic [15:0] STABLE_TIME_RESET     = 16'd500;
    localparam logic [15:0] SAMPLE_INTERVAL_RESET = 16'd50;

    function automatic logic [1:0] rot_of_dir(input t_dir dir);
        logic [1:0] rot;
        case (dir)
            DIR_POS_X: rot = 2'd1;
            DIR_NEG_X: rot = 2'd3;
            DIR_POS_Y: rot = 2'd0;
            DIR_NEG_Y: rot = 2'd2;
            default:   rot = 2'd0;
        endcase
        return rot;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gravity_orientation_detector.sv
// Top level of the gravity orientation detector with its register port and sample pipeline.
//
//   Channel   Direction  Handshake                    Payload
//   sample    in         i_in_valid / o_in_ready      now_ms, read_ok, accel_x_mg, accel_y_mg
//   result    out        o_out_valid / i_out_ready    rotation_changed, display_rotation,
//                                                     stable_direction, candidate_direction
//   config    in         psel, penable, pwrite, pready  APB registers at 4*index
//
// Each transaction is held in the input register and then moves to the result register,
// which presents it; one sample is taken per cycle while the result side does not stall.
// The state update and classification run combinationally between those two registers.
// A stall on the result side holds both registers; the sample side keeps accepting while the input
// register is empty. Reset is synchronous; it returns valid, state and config registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module gravity_orientation_detector (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [31:0]                i_now_ms,
    input  wire logic                       i_read_ok,
    input  wire logic signed [14:0]         i_accel_x_mg,
    input  wire logic signed [14:0]         i_accel_y_mg,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_rotation_changed,
    output logic [1:0]                      o_display_rotation,
    output logic [2:0]                      o_stable_direction,
    output logic [2:0]                      o_candidate_direction,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [gor_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic        r_sensor_ready;
    logic [13:0] r_axis_min;
    logic [13:0] r_hysteresis;
    logic [15:0] r_stable_time;
    logic [15:0] r_sample_interval;
    logic [1:0]  r_mount_turns;
    logic        r_auto_rotate;

    logic              r_in_valid;
    logic [31:0]       r_now;
    logic              r_read_ok;
    logic [14:0]       r_x;
    logic [14:0]       r_y;

    logic              r_out_valid;
    logic              r_changed;

    logic [31:0]       r_last_time;
    gor_pkg::t_dir     r_cand;
    logic [31:0]       r_cand_start;
    gor_pkg::t_dir     r_stable;
    logic [1:0]        r_rotation;

    logic              out_load;
    logic              fire;
    logic              cfg_write;
    logic [2:0]        reg_idx;

    logic              take;
    logic              good;
    logic [14:0]       ax;
    logic [14:0]       ay;
    logic              x_dominant;
    logic [14:0]       strongest;
    logic [14:0]       diff;
    gor_pkg::t_dir     class_dir;
    gor_pkg::t_dir     n_cand;
    logic [31:0]       n_cand_start;
    logic              promote;
    logic [1:0]        new_rot;
    logic              n_changed;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_ready    <= 1'b1;
            r_axis_min        <= gor_pkg::AXIS_MIN_RESET;
            r_hysteresis      <= gor_pkg::HYSTERESIS_RESET;
            r_stable_time     <= gor_pkg::STABLE_TIME_RESET;
            r_sample_interval <= gor_pkg::SAMPLE_INTERVAL_RESET;
            r_mount_turns     <= 2'd0;
            r_auto_rotate     <= 1'b1;
        end else if (cfg_write) begin
            case (reg_idx)
                gor_pkg::REG_SENSOR_READY:    r_sensor_ready    <= pwdata[0];
                gor_pkg::REG_AXIS_MIN:        r_axis_min        <= pwdata[13:0];
                gor_pkg::REG_HYSTERESIS:      r_hysteresis      <= pwdata[13:0];
                gor_pkg::REG_STABLE_TIME:     r_stable_time     <= pwdata[15:0];
                gor_pkg::REG_SAMPLE_INTERVAL: r_sample_interval <= pwdata[15:0];
                gor_pkg::REG_MOUNT_TURNS:     r_mount_turns     <= pwdata[1:0];
                gor_pkg::REG_AUTO_ROTATE:     r_auto_rotate     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gor_pkg::REG_SENSOR_READY:    prdata = {31'd0, r_sensor_ready};
            gor_pkg::REG_AXIS_MIN:        prdata = {18'd0, r_axis_min};
            gor_pkg::REG_HYSTERESIS:      prdata = {18'd0, r_hysteresis};
            gor_pkg::REG_STABLE_TIME:     prdata = {16'd0, r_stable_time};
            gor_pkg::REG_SAMPLE_INTERVAL: prdata = {16'd0, r_sample_interval};
            gor_pkg::REG_MOUNT_TURNS:     prdata = {30'd0, r_mount_turns};
            gor_pkg::REG_AUTO_ROTATE:     prdata = {31'd0, r_auto_rotate};
            default:                      prdata = 32'd0;
        endcase
    end

    assign out_load   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_load;
    assign o_in_ready = !r_in_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_now     <= i_now_ms;
            r_read_ok <= i_read_ok;
            r_x       <= i_accel_x_mg;
            r_y       <= i_accel_y_mg;
        end
    end

    always_comb begin
        take       = r_sensor_ready && ((r_now - r_last_time) >= {16'd0, r_sample_interval});
        good       = take && r_read_ok;
        ax         = r_x[14] ? (~r_x + 15'd1) : r_x;
        ay         = r_y[14] ? (~r_y + 15'd1) : r_y;
        x_dominant = (ax >= ay);
        strongest  = x_dominant ? ax : ay;
        diff       = x_dominant ? (ax - ay) : (ay - ax);

        if (strongest < {1'b0, r_axis_min}) begin
            class_dir = gor_pkg::DIR_UNKNOWN;
        end else if ((diff < {1'b0, r_hysteresis}) && (r_cand != gor_pkg::DIR_UNKNOWN)) begin
            class_dir = r_cand;
        end else if ((diff < {1'b0, r_hysteresis}) && (r_stable != gor_pkg::DIR_UNKNOWN)) begin
            class_dir = r_stable;
        end else if (x_dominant) begin
            class_dir = r_x[14] ? gor_pkg::DIR_NEG_X : gor_pkg::DIR_POS_X;
        end else begin
            class_dir = r_y[14] ? gor_pkg::DIR_NEG_Y : gor_pkg::DIR_POS_Y;
        end

        n_cand       = good ? class_dir : r_cand;
        n_cand_start = (good && (class_dir != r_cand)) ? r_now : r_cand_start;
        promote      = good && (n_cand != gor_pkg::DIR_UNKNOWN) && (n_cand != r_stable)
                       && ((r_now - n_cand_start) >= {16'd0, r_stable_time});
        new_rot      = gor_pkg::rot_of_dir(n_cand) - r_mount_turns;
        n_changed    = promote && r_auto_rotate && (new_rot != r_rotation);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= 32'd0;
            r_cand       <= gor_pkg::DIR_UNKNOWN;
            r_cand_start <= 32'd0;
            r_stable     <= gor_pkg::DIR_UNKNOWN;
            r_rotation   <= 2'd0;
        end else if (fire) begin
            if (take) begin
                r_last_time <= r_now;
            end
            r_cand       <= n_cand;
            r_cand_start <= n_cand_start;
            if (promote) begin
                r_stable <= n_cand;
            end
            if (n_changed) begin
                r_rotation <= new_rot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_changed <= n_changed;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_rotation_changed    = r_changed;
    assign o_display_rotation    = r_rotation;
    assign o_stable_direction    = r_stable;
    assign o_candidate_direction = r_cand;

endmodule

`default_nettype wire

>>> rtl/gor_checker.sv
// Port-level assertions for the gravity orientation detector and their bind.
`timescale 1ns / 1ps
`default_nettype none

module gor_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic       o_rotation_changed,
    input wire logic [1:0] o_display_rotation,
    input wire logic [2:0] o_stable_direction,
    input wire logic [2:0] o_candidate_direction
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rotation_changed)
        && $stable(o_display_rotation) && $stable(o_stable_direction)
        && $stable(o_candidate_direction))
        else $error("Result changed while stalled.");

    a_change_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rotation_changed |->
        o_stable_direction != gor_pkg::DIR_UNKNOWN)
        else $error("Rotation changed without a known stable direction.");

    a_change_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rotation_changed |-> o_stable_direction == o_candidate_direction)
        else $error("Rotation changed while candidate differs from stable direction.");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("Input stalled without an output stall.");

endmodule

bind gravity_orientation_detector gor_checker u_gor_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_in_ready            (o_in_ready),
    .o_out_valid           (o_out_valid),
    .i_out_ready           (i_out_ready),
    .o_rotation_changed    (o_rotation_changed),
    .o_display_rotation    (o_display_rotation),
    .o_stable_direction    (o_stable_direction),
    .o_candidate_direction (o_candidate_direction)
);

`default_nettype wire

>>> test/gravity_orientation_detector_test.sv
// Self-checking testbench for the gravity orientation detector with randomized handshake idling.
`timescale 1ns / 1ps

module gravity_orientation_detector_test;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int END_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_SAMPLES = 50;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic          changed;
        logic [1:0]    rotation;
        gor_pkg::t_dir stable;
        gor_pkg::t_dir candidate;
    } t_orientation;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [31:0] i_now_ms;
    logic i_read_ok;
    logic signed [14:0] i_accel_x_mg;
    logic signed [14:0] i_accel_y_mg;
    logic o_out_valid;
    logic i_out_ready;
    logic o_rotation_changed;
    logic [1:0] o_display_rotation;
    logic [2:0] o_stable_direction;
    logic [2:0] o_candidate_direction;
    logic psel;
    logic penable;
    logic pwrite;
    logic [gor_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    logic        cfg_sensor_ready;
    logic [13:0] cfg_axis_min;
    logic [13:0] cfg_hysteresis;
    logic [15:0] cfg_stable_time;
    logic [15:0] cfg_interval;
    logic [1:0]  cfg_mount;
    logic        cfg_auto_rotate;

    logic [31:0]   last_sample_ms;
    gor_pkg::t_dir cand_dir;
    logic [31:0]   cand_start_ms;
    gor_pkg::t_dir stable_dir;
    logic [1:0]    shown_rotation;

    t_orientation expected_q[$];
    int mismatch_count = 0;
    int quiet_cycles = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_off_request = 1'b0;
    logic [31:0] clock_ms = 32'd0;

    gravity_orientation_detector dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_now_ms              (i_now_ms),
        .i_read_ok             (i_read_ok),
        .i_accel_x_mg          (i_accel_x_mg),
        .i_accel_y_mg          (i_accel_y_mg),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_rotation_changed    (o_rotation_changed),
        .o_display_rotation    (o_display_rotation),
        .o_stable_direction    (o_stable_direction),
        .o_candidate_direction (o_candidate_direction),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void reset_orientation_state();
        cfg_sensor_ready = 1'b1;
        cfg_axis_min     = gor_pkg::AXIS_MIN_RESET;
        cfg_hysteresis   = gor_pkg::HYSTERESIS_RESET;
        cfg_stable_time  = gor_pkg::STABLE_TIME_RESET;
        cfg_interval     = gor_pkg::SAMPLE_INTERVAL_RESET;
        cfg_mount        = 2'd0;
        cfg_auto_rotate  = 1'b1;
        last_sample_ms   = 32'd0;
        cand_dir         = gor_pkg::DIR_UNKNOWN;
        cand_start_ms    = 32'd0;
        stable_dir       = gor_pkg::DIR_UNKNOWN;
        shown_rotation   = 2'd0;
    endfunction

    function automatic gor_pkg::t_dir classify_tilt(logic signed [14:0] x,
            logic signed [14:0] y);
        int ax;
        int ay;
        int strongest;
        int spread;
        ax = (x < 0) ? -int'(x) : int'(x);
        ay = (y < 0) ? -int'(y) : int'(y);
        strongest = (ax > ay) ? ax : ay;
        spread = (ax > ay) ? ax - ay : ay - ax;
        if (strongest < int'(cfg_axis_min)) return gor_pkg::DIR_UNKNOWN;
        if (spread < int'(cfg_hysteresis)) begin
            if (cand_dir != gor_pkg::DIR_UNKNOWN) return cand_dir;
            if (stable_dir != gor_pkg::DIR_UNKNOWN) return stable_dir;
        end
        if (ax >= ay) return (x >= 0) ? gor_pkg::DIR_POS_X : gor_pkg::DIR_NEG_X;
        return (y >= 0) ? gor_pkg::DIR_POS_Y : gor_pkg::DIR_NEG_Y;
    endfunction

    function automatic t_orientation predict_orientation(logic [31:0] now, logic ok,
            logic signed [14:0] x, logic signed [14:0] y);
        t_orientation res;
        gor_pkg::t_dir next_dir;
        logic [31:0] since_last;
        logic [31:0] since_cand;
        logic [1:0] base_rot;
        logic [1:0] new_rot;
        res.changed = 1'b0;
        since_last = now - last_sample_ms;
        if (cfg_sensor_ready && since_last >= {16'd0, cfg_interval}) begin
            last_sample_ms = now;
            if (ok) begin
                next_dir = classify_tilt(x, y);
                if (next_dir != cand_dir) begin
                    cand_dir = next_dir;
                    cand_start_ms = now;
                end
                since_cand = now - cand_start_ms;
                if (cand_dir != gor_pkg::DIR_UNKNOWN && cand_dir != stable_dir &&
                        since_cand >= {16'd0, cfg_stable_time}) begin
                    stable_dir = cand_dir;
                    case (stable_dir)
                        gor_pkg::DIR_POS_X: base_rot = 2'd1;
                        gor_pkg::DIR_NEG_X: base_rot = 2'd3;
                        gor_pkg::DIR_NEG_Y: base_rot = 2'd2;
                        default: base_rot = 2'd0;
                    endcase
                    new_rot = base_rot - cfg_mount;
                    if (cfg_auto_rotate && new_rot != shown_rotation) begin
                        shown_rotation = new_rot;
                        res.changed = 1'b1;
                    end
                end
            end
        end
        res.rotation = shown_rotation;
        res.stable = stable_dir;
        res.candidate = cand_dir;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        $display("%0t ns: %s is %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic send_sample(logic [31:0] now, logic ok,
            logic signed [14:0] x, logic signed [14:0] y);
        int gap;
        gap = sender_idles ? $urandom_range(0, 9) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ms <= now;
        i_read_ok <= ok;
        i_accel_x_mg <= x;
        i_accel_y_mg <= y;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        expected_q.push_back(predict_orientation(now, ok, x, y));
    endtask

    task automatic send_after(int step_ms, logic ok, int x, int y);
        clock_ms = clock_ms + step_ms;
        send_sample(clock_ms, ok, 15'(x), 15'(y));
    endtask

    task automatic wait_for_results;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        wait_for_results();
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            gor_pkg::REG_SENSOR_READY:    cfg_sensor_ready = value[0];
            gor_pkg::REG_AXIS_MIN:        cfg_axis_min = value[13:0];
            gor_pkg::REG_HYSTERESIS:      cfg_hysteresis = value[13:0];
            gor_pkg::REG_STABLE_TIME:     cfg_stable_time = value[15:0];
            gor_pkg::REG_SAMPLE_INTERVAL: cfg_interval = value[15:0];
            gor_pkg::REG_MOUNT_TURNS:     cfg_mount = value[1:0];
            gor_pkg::REG_AUTO_ROTATE:     cfg_auto_rotate = value[0];
            default: ;
        endcase
    endtask

    task automatic pick_random_settings;
        write_register(gor_pkg::REG_SENSOR_READY, 32'($urandom_range(0, 9) != 0));
        write_register(gor_pkg::REG_AXIS_MIN,
                       ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 3000));
        write_register(gor_pkg::REG_HYSTERESIS,
                       ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 2500));
        write_register(gor_pkg::REG_STABLE_TIME, $urandom_range(0, 400));
        write_register(gor_pkg::REG_SAMPLE_INTERVAL, $urandom_range(0, 100));
        write_register(gor_pkg::REG_MOUNT_TURNS, $urandom_range(0, 3));
        write_register(gor_pkg::REG_AUTO_ROTATE, 32'($urandom_range(0, 9) != 0));
    endtask

    // Mostly runs of samples that lean one way, usually at a legal pace, mixed with raw noise.
    task automatic send_random_samples(int count);
        int sent;
        int run;
        int k;
        int pick;
        int lo;
        int mag;
        int minor;
        logic signed [14:0] x;
        logic signed [14:0] y;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                x = 15'($urandom);
                y = 15'($urandom);
                clock_ms = (pick < 5) ? $urandom : clock_ms + $urandom_range(0, 300);
                send_sample(clock_ms, 1'($urandom_range(0, 1)), x, y);
                sent++;
            end else begin
                pick = $urandom_range(1, 4);
                run = $urandom_range(1, 8);
                for (k = 0; k < run && sent < count; k++) begin
                    lo = int'(cfg_axis_min) - 50;
                    if (lo < 0) lo = 0;
                    if (lo > 16383) lo = 16383;
                    mag = $urandom_range(lo, 16383);
                    if ($urandom_range(0, 4) == 0)
                        minor = mag - $urandom_range(0, int'(cfg_hysteresis) + 20);
                    else
                        minor = $urandom_range(0, mag);
                    if (minor < 0) minor = 0;
                    if ($urandom_range(0, 1) == 0) minor = -minor;
                    case (pick)
                        1: begin x = 15'(mag); y = 15'(minor); end
                        2: begin x = 15'(-mag); y = 15'(minor); end
                        3: begin x = 15'(minor); y = 15'(mag); end
                        default: begin x = 15'(minor); y = 15'(-mag); end
                    endcase
                    if ($urandom_range(0, 9) == 0)
                        clock_ms = clock_ms + $urandom_range(0, cfg_interval);
                    else
                        clock_ms = clock_ms + cfg_interval + $urandom_range(0, 120);
                    send_sample(clock_ms, ($urandom_range(0, 19) != 0), x, y);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_gating_and_directions;
        clock_ms = 32'd0;
        send_after(0, 1'b1, 1000, -1000);
        send_after(60, 1'b0, 16383, 0);
        send_after(20, 1'b1, 16383, 0);
        send_after(120, 1'b1, 1000, -1000);
        send_after(500, 1'b1, 16383, 100);
        send_after(100, 1'b1, -16384, 0);
        send_after(500, 1'b1, -16384, -16384);
        send_after(100, 1'b1, 0, 16383);
        send_after(500, 1'b1, 5, 16383);
        send_after(100, 1'b1, 100, -16384);
        send_after(500, 1'b1, -100, -16000);
        send_after(100, 1'b1, 499, -300);
        send_after(100, 1'b1, 1000, 950);
        clock_ms = 32'hFFFF_FFC0;
        send_after(0, 1'b1, 600, 0);
        send_after(512, 1'b1, 600, 0);
    endtask

    task automatic test_sensor_off;
        write_register(gor_pkg::REG_SENSOR_READY, 32'd0);
        send_after(100, 1'b1, -16384, 0);
        write_register(gor_pkg::REG_SENSOR_READY, 32'd1);
    endtask

    task automatic test_rotation_controls;
        write_register(gor_pkg::REG_STABLE_TIME, 32'd0);
        write_register(gor_pkg::REG_SAMPLE_INTERVAL, 32'd0);
        write_register(gor_pkg::REG_AUTO_ROTATE, 32'd0);
        send_after(0, 1'b1, 0, -16384);
        write_register(gor_pkg::REG_AUTO_ROTATE, 32'd1);
        write_register(gor_pkg::REG_MOUNT_TURNS, 32'd3);
        send_after(0, 1'b1, 16383, 0);
        send_after(0, 1'b1, 0, 16383);
    endtask

    task automatic test_register_extremes;
        write_register(gor_pkg::REG_AXIS_MIN, 32'd0);
        write_register(gor_pkg::REG_HYSTERESIS, 32'd0);
        send_after(1, 1'b1, 0, 0);
        write_register(gor_pkg::REG_AXIS_MIN, 32'hFFFF_FFFF);
        write_register(gor_pkg::REG_HYSTERESIS, 32'hFFFF_FFFF);
        write_register(gor_pkg::REG_STABLE_TIME, 32'hFFFF_FFFF);
        write_register(gor_pkg::REG_SAMPLE_INTERVAL, 32'hFFFF_FFFF);
        write_register(gor_pkg::REG_MOUNT_TURNS, 32'hFFFF_FFFF);
        send_after(65535, 1'b1, -16383, 0);
        send_after(65534, 1'b1, -16383, 0);
        send_after(1, 1'b1, -16383, 0);
    endtask

    task automatic test_unused_register;
        write_register(REG_UNUSED, 32'd0);
        send_after(65535, 1'b1, 16383, 16383);
    endtask

    task automatic test_full_backpressure;
        sender_idles = 1'b0;
        receiver_idles = 1'b1;
        hold_off_request = 1'b1;
        send_random_samples(24);
        wait_for_results();
        sender_idles = 1'b1;
    endtask

    task automatic test_random_traffic;
        int phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_random_settings();
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            send_random_samples(PHASE_SAMPLES);
        end
    endtask

    initial begin : result_checker
        int gap;
        t_orientation want;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = receiver_idles ? $urandom_range(0, 9) : 0;
            if (hold_off_request) begin
                gap = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (expected_q.size() == 0) begin
                report_mismatch("result with no sample outstanding, queue size", 0, 1);
            end else begin
                want = expected_q.pop_front();
                if (o_rotation_changed !== want.changed)
                    report_mismatch("rotation_changed", o_rotation_changed, want.changed);
                if (o_display_rotation !== want.rotation)
                    report_mismatch("display_rotation", o_display_rotation, want.rotation);
                if (o_stable_direction !== want.stable)
                    report_mismatch("stable_direction", o_stable_direction, want.stable);
                if (o_candidate_direction !== want.candidate)
                    report_mismatch("candidate_direction", o_candidate_direction,
                                    want.candidate);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("gravity_orientation_detector: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_now_ms = 32'd0;
        i_read_ok = 1'b0;
        i_accel_x_mg = 15'sd0;
        i_accel_y_mg = 15'sd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        reset_orientation_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_gating_and_directions();
        test_sensor_off();
        test_rotation_controls();
        test_register_extremes();
        test_unused_register();
        test_full_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("gravity_orientation_detector: match");
        else
            $display("gravity_orientation_detector: mismatch");
        $finish;
    end

endmodule
